>>> sv/mel_pkg.sv
// Shared types, widths and constants of the multichannel EMA low-pass filter.
`default_nettype none

package mel_pkg;

   localparam int unsigned DEFAULT_CHANNELS = 16;

   localparam int unsigned DATA_W  = 32;  // Q16.16 sample and smoothed value
   localparam int unsigned CHAN_W  = 8;   // channel field
   localparam int unsigned MODE_W  = 2;   // filter mode field
   localparam int unsigned COEF_W  = 16;  // Q0.16 coefficient
   localparam int unsigned FRAC_W  = 16;  // fraction bits of the coefficient
   localparam int unsigned BETA_W  = COEF_W + 1;          // 65536 - alpha, up to 65536
   localparam int unsigned SA_W    = DATA_W + COEF_W + 1; // sample * alpha
   localparam int unsigned PROD_W  = DATA_W + BETA_W + 1; // old * beta plus sum headroom

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [COEF_W-1:0] SLOW_COEF_RESET = 16'd2163;
   localparam logic [COEF_W-1:0] FAST_COEF_RESET = 16'd8192;
   localparam logic [BETA_W-1:0] COEF_ONE        = 17'h10000;

   // Register indexes as decoded from paddr[2].
   localparam logic REG_SLOW_COEF = 1'b0;
   localparam logic REG_FAST_COEF = 1'b1;

   // Filter mode codes; the unused code behaves as slow.
   localparam logic [MODE_W-1:0] MODE_FAST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLOW  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      KIND_FILTER,
      KIND_CLEAR,
      KIND_BYPASS
   } kind_type;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      kind_type                   kind;
      logic [CHAN_W-1:0]          chan;
      logic signed [DATA_W-1:0]   sample;
      logic [BETA_W-1:0]          beta;
      logic signed [SA_W-1:0]     sa;
   } q_entry_type;

endpackage

`default_nettype wire

>>> sv/multichannel_ema_lowpass.sv
// Throughput: one item per cycle while the result channel is not stalled, also for the same
// channel back to back; the bound is the update loop in the back end (one 32x18 multiply
// and one add, with forwarding).
// Reset: synchronous, active high; coefficients return to 2163 and 8192, every channel
// reads as zero at once through per-channel written flags, and the queue empties.
`default_nettype none

module multichannel_ema_lowpass #(
   parameter int unsigned CHANNELS = mel_pkg::DEFAULT_CHANNELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [mel_pkg::DATA_W-1:0] req_sample,
   input  wire logic [mel_pkg::CHAN_W-1:0]        req_channel,
   input  wire logic [mel_pkg::MODE_W-1:0]        req_filter_mode,
   // Result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [mel_pkg::DATA_W-1:0]      rsp_filtered,
   // Register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [mel_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [mel_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mel_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import mel_pkg::*;

   // Coefficient registers. Address 0 holds the slow alpha, address 4 the fast
   // alpha; the low address bits are ignored, so paddr[2] picks the register.
   logic [COEF_W-1:0] slow_coef_ff, slow_coef_in;
   logic [COEF_W-1:0] fast_coef_ff, fast_coef_in;
   logic              csr_write;

   // Transfers between the front end, the queue and the back end.
   logic        push_valid, push_ready, pop_valid, pop_ready;
   q_entry_type push_entry, pop_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      slow_coef_in = slow_coef_ff;
      fast_coef_in = fast_coef_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_SLOW_COEF: slow_coef_in = pwdata[COEF_W-1:0];
            REG_FAST_COEF: fast_coef_in = pwdata[COEF_W-1:0];
            default:       slow_coef_in = slow_coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_coef_ff <= SLOW_COEF_RESET;
         fast_coef_ff <= FAST_COEF_RESET;
      end else begin
         slow_coef_ff <= slow_coef_in;
         fast_coef_ff <= fast_coef_in;
      end
   end

   // Read data is a plain mux of the two coefficients, zero-extended.
   always_comb begin
      unique case (paddr[2])
         REG_SLOW_COEF: prdata = CSR_DATA_W'(slow_coef_ff);
         REG_FAST_COEF: prdata = CSR_DATA_W'(fast_coef_ff);
         default:       prdata = '0;
      endcase
   end

   // The front end registers each accepted item, decides whether it filters,
   // clears or bypasses, picks alpha and forms sample * alpha, which does not
   // depend on the stored value and so stays out of the update loop.
   mel_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_channel     (req_channel),
      .req_filter_mode (req_filter_mode),
      .slow_coef       (slow_coef_ff),
      .fast_coef       (fast_coef_ff),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .push_ready      (push_ready)
   );

   // The queue lets the front end keep taking transfers while a finished
   // result waits on the output.
   mel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // The back end registers the channel's smoothed value from its memory as the
   // item leaves the queue, forwards the value written in the same cycle as that read,
   // updates the value, writes it back and loads the output register.
   mel_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_entry    (pop_entry),
      .pop_ready    (pop_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered)
   );

endmodule

`default_nettype wire

>>> sv/mel_front.sv
// Front end: accepts input items, classifies them and precomputes sample * alpha.
`default_nettype none

module mel_front #(
   parameter int unsigned CHANNELS = mel_pkg::DEFAULT_CHANNELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [mel_pkg::DATA_W-1:0] req_sample,
   input  wire logic [mel_pkg::CHAN_W-1:0]        req_channel,
   input  wire logic [mel_pkg::MODE_W-1:0]        req_filter_mode,
   input  wire logic [mel_pkg::COEF_W-1:0]        slow_coef,
   input  wire logic [mel_pkg::COEF_W-1:0]        fast_coef,
   output logic                                   push_valid,
   output mel_pkg::q_entry_type                   push_entry,
   input  wire logic                              push_ready
);
   import mel_pkg::*;

   logic                     fe_valid_ff, fe_valid_in;
   logic signed [DATA_W-1:0] fe_sample_ff;
   logic [CHAN_W-1:0]        fe_chan_ff;
   kind_type                 fe_kind_ff, kind;
   logic [COEF_W-1:0]        fe_alpha_ff, alpha;
   logic                     accept;

   assign req_ready = !fe_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      alpha = slow_coef;
      kind  = KIND_FILTER;
      unique case (req_filter_mode)
         MODE_FAST: begin
            alpha = fast_coef;
         end
         MODE_CLEAR: begin
            kind = KIND_CLEAR;
         end
         default: begin
            alpha = slow_coef;
         end
      endcase
      if ({1'b0, req_channel} >= (CHAN_W + 1)'(CHANNELS)) begin
         kind = KIND_BYPASS;
      end
   end

   always_comb begin
      fe_valid_in = fe_valid_ff;
      if (accept) begin
         fe_valid_in = 1'b1;
      end else if (push_ready) begin
         fe_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff <= fe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fe_sample_ff <= req_sample;
         fe_chan_ff   <= req_channel;
         fe_kind_ff   <= kind;
         fe_alpha_ff  <= alpha;
      end
   end

   always_comb begin
      push_valid        = fe_valid_ff;
      push_entry.kind   = fe_kind_ff;
      push_entry.chan   = fe_chan_ff;
      push_entry.sample = fe_sample_ff;
      push_entry.beta   = COEF_ONE - {1'b0, fe_alpha_ff};
      push_entry.sa     = fe_sample_ff * $signed({1'b0, fe_alpha_ff});
   end

endmodule

`default_nettype wire

>>> sv/mel_queue.sv
// Small FIFO that decouples the front end from the back end.
`default_nettype none

module mel_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire mel_pkg::q_entry_type push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output mel_pkg::q_entry_type      pop_entry,
   input  wire logic                 pop_ready
);
   import mel_pkg::*;

   q_entry_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/mel_back.sv
// Back end: per-channel store, forwarding and the filter update loop.
`default_nettype none

module mel_back #(
   parameter int unsigned CHANNELS = mel_pkg::DEFAULT_CHANNELS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop_valid,
   input  wire mel_pkg::q_entry_type        pop_entry,
   output logic                             pop_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [mel_pkg::DATA_W-1:0] rsp_filtered
);
   import mel_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic signed [DATA_W-1:0] store_mem [CHANNELS];
   logic [CHANNELS-1:0]      written_ff;

   logic                     rd_valid_ff;
   q_entry_type              rd_entry_ff;
   logic signed [DATA_W-1:0] mem_rd_ff;
   logic                     written_rd_ff;
   logic                     fwd_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_filtered_ff;

   logic                     advance, wr_en, pop;
   logic [IDX_W-1:0]         wr_idx, rd_idx;
   logic signed [DATA_W-1:0] old_value, new_value, wr_value, out_value;
   logic signed [PROD_W-1:0] old_beta, total;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;
   assign pop       = pop_valid && advance;
   assign wr_idx    = rd_entry_ff.chan[IDX_W-1:0];
   assign rd_idx    = pop_entry.chan[IDX_W-1:0];
   assign wr_en     = advance && rd_valid_ff && (rd_entry_ff.kind != KIND_BYPASS);

   // new = floor((sample * alpha + old * (1 - alpha)) / 2^16), which equals
   // old + floor((sample - old) * alpha / 2^16) and always fits 32 bits.
   always_comb begin
      if (fwd_ff) begin
         old_value = rsp_filtered_ff;
      end else if (written_rd_ff) begin
         old_value = mem_rd_ff;
      end else begin
         old_value = '0;
      end
      old_beta  = old_value * $signed({1'b0, rd_entry_ff.beta});
      total     = old_beta + PROD_W'(rd_entry_ff.sa);
      new_value = total[FRAC_W +: DATA_W];
      wr_value  = (rd_entry_ff.kind == KIND_CLEAR) ? '0 : new_value;
      out_value = (rd_entry_ff.kind == KIND_BYPASS) ? rd_entry_ff.sample : wr_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         written_ff   <= '0;
      end else begin
         if (advance) begin
            rd_valid_ff  <= pop_valid;
            rsp_valid_ff <= rd_valid_ff;
            fwd_ff       <= wr_en && (wr_idx == rd_idx);
         end
         if (wr_en) begin
            written_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_entry_ff     <= pop_entry;
         rsp_filtered_ff <= out_value;
      end
      if (pop) begin
         written_rd_ff <= written_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_idx] <= wr_value;
      end
      if (pop) begin
         mem_rd_ff <= store_mem[rd_idx];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the multichannel EMA low-pass filter.
`timescale 1ns / 100ps

module tb_top;
   import mel_pkg::*;

   localparam int unsigned NUM_CHANNELS = DEFAULT_CHANNELS;
   // The fourth mode code is not named in the package; the block treats it as slow.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned SEGMENTS = 8;
   localparam int unsigned SEGMENT_ITEMS = 129;
   localparam int unsigned MAX_REPORTS = 10;

   // Tracks the per-channel smoothed values and coefficients, predicts each
   // filtered result and compares it with what the block returns.
   class ema_tracker;
      logic signed [DATA_W-1:0] smoothed [NUM_CHANNELS];
      logic [COEF_W-1:0]        slow_coef;
      logic [COEF_W-1:0]        fast_coef;
      logic signed [DATA_W-1:0] expected_filtered [$];
      int unsigned              mismatches;
      int unsigned              compared;

      function new();
         foreach (smoothed[i]) smoothed[i] = '0;
         slow_coef = SLOW_COEF_RESET;
         fast_coef = FAST_COEF_RESET;
         mismatches = 0;
         compared = 0;
      endfunction

      function void set_coefficient(logic reg_index, logic [COEF_W-1:0] value);
         if (reg_index == REG_SLOW_COEF) slow_coef = value;
         else fast_coef = value;
      endfunction

      function void record_input(logic signed [DATA_W-1:0] sample,
                                 logic [CHAN_W-1:0] channel,
                                 logic [MODE_W-1:0] mode);
         logic [COEF_W-1:0] alpha;
         longint            old_value;
         longint            scaled;
         longint            next_value;
         if (channel >= NUM_CHANNELS) begin
            expected_filtered.push_back(sample);
            return;
         end
         alpha = (mode == MODE_FAST) ? fast_coef : slow_coef;
         old_value = smoothed[channel];
         scaled = (longint'(sample) - old_value) * longint'(alpha);
         // Arithmetic shift of a signed 64-bit value floors toward minus infinity.
         next_value = old_value + (scaled >>> FRAC_W);
         if (next_value > 64'sd2147483647) next_value = 64'sd2147483647;
         if (next_value < -64'sd2147483648) next_value = -64'sd2147483648;
         if (mode == MODE_CLEAR) next_value = 0;
         smoothed[channel] = next_value[DATA_W-1:0];
         expected_filtered.push_back(next_value[DATA_W-1:0]);
      endfunction

      function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      endfunction

      function void check_output(logic signed [DATA_W-1:0] actual);
         logic signed [DATA_W-1:0] want;
         if (expected_filtered.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result %h arrived with no sample pending", $realtime, actual);
            return;
         end
         want = expected_filtered.pop_front();
         compared++;
         if (actual !== want) report_mismatch("filtered", want, actual);
      endfunction

      function int pending();
         return expected_filtered.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [DATA_W-1:0]  req_sample;
   logic [CHAN_W-1:0]         req_channel;
   logic [MODE_W-1:0]         req_filter_mode;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [DATA_W-1:0]  rsp_filtered;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0]     pwdata;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   ema_tracker  tracker;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned accepted_count;
   int unsigned settings_written;

   multichannel_ema_lowpass dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_channel     (req_channel),
      .req_filter_mode (req_filter_mode),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 20 ns clock period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The receiver decides at every falling edge whether it takes a result in the
   // next cycle; the stall rate follows the current idling pattern.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   // Both channels are observed at the rising edge. An input transfer is fed to
   // the predictor before the result transfer of the same edge is checked; the
   // block's latency means the two can never belong to the same item anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.record_input(req_sample, req_channel, req_filter_mode);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) tracker.check_output(rsp_filtered);
      end
   end

   // Offers one sample. It is entered and left just after a falling edge. Valid
   // stays high when the next call presents its item without a gap, so the
   // signal is never lowered and raised within one time step.
   task automatic send_sample(input logic signed [DATA_W-1:0] sample,
                              input logic [CHAN_W-1:0] channel,
                              input logic [MODE_W-1:0] mode);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample = sample;
      req_channel = channel;
      req_filter_mode = mode;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Writes one coefficient register, then reads it back. The upper half of
   // pwdata carries random bits that the block has to discard.
   task automatic csr_write(input logic reg_index, input logic [COEF_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {reg_index, 2'b00};
      pwdata = {16'($urandom_range(65535)), value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_coefficient(reg_index, value);
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      if (readback[COEF_W-1:0] !== value)
         tracker.report_mismatch("coefficient read-back", {16'd0, value}, readback);
      settings_written++;
   endtask

   // Waits until every expected result has arrived, then lets the pipeline
   // settle.
   task automatic wait_for_quiet();
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      @(negedge clock);
   endtask

   // Runaway guard, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("multichannel_ema_lowpass test failed");
      $finish;
   end

   initial begin
      int unsigned                  pick;
      int unsigned                  directed_count;
      logic signed [DATA_W-1:0]     sample;
      logic [CHAN_W-1:0]            channel;
      logic [MODE_W-1:0]            mode;
      logic [COEF_W-1:0]            slow_value;
      logic [COEF_W-1:0]            fast_value;

      tracker = new();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      accepted_count = 0;
      settings_written = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_channel = '0;
      req_filter_mode = MODE_FAST;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, run with the reset coefficients and no idling. It walks
      // the sample extremes through channel 0, shows the floor rounding of a
      // small negative step, and hits the unused mode code, clears inside the
      // range, and out-of-range channels where even a clear must pass through.
      send_sample(32'sh7FFFFFFF, 8'd0, MODE_FAST);
      send_sample(32'sh7FFFFFFF, 8'd0, MODE_FAST);
      send_sample(32'sh80000000, 8'd0, MODE_SLOW);
      send_sample(-32'sd1, 8'd0, MODE_UNUSED);
      send_sample(32'sh12345678, 8'd0, MODE_CLEAR);
      send_sample(32'sd1, 8'd0, MODE_FAST);
      send_sample(-32'sd1, 8'd1, MODE_FAST);
      send_sample(32'sd0, 8'd1, MODE_SLOW);
      send_sample(32'sh80000000, 8'd15, MODE_SLOW);
      send_sample(32'sh7FFFFFFF, 8'd15, MODE_FAST);
      send_sample(-32'sd65536, 8'd15, MODE_CLEAR);
      send_sample(32'sh7FFFFFFF, 8'd15, MODE_FAST);
      send_sample(32'sd12345, 8'(NUM_CHANNELS), MODE_FAST);
      send_sample(32'sh80000000, 8'd255, MODE_CLEAR);
      send_sample(32'sh7FFFFFFF, 8'd128, MODE_UNUSED);
      send_sample(32'sd0, 8'd255, MODE_SLOW);
      // Back-to-back updates of one channel exercise the forwarding path.
      send_sample(32'sd65536, 8'd7, MODE_FAST);
      send_sample(32'sd65536, 8'd7, MODE_FAST);
      send_sample(32'sd65536, 8'd7, MODE_SLOW);
      send_sample(-32'sd65536, 8'd7, MODE_UNUSED);
      send_sample(32'sh80000000, 8'd7, MODE_CLEAR);
      directed_count = accepted_count;

      // Random part. Every segment starts from a quiet block with a fresh pair
      // of coefficients, the first four covering 0, 1, the midpoint and the
      // maximum, and cycles through the four idling patterns: none, sender
      // only, receiver only, then both.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_quiet();
         case (seg)
            0: begin
               slow_value = 16'd65535;
               fast_value = 16'd0;
            end
            1: begin
               slow_value = 16'd0;
               fast_value = 16'd65535;
            end
            2: begin
               slow_value = 16'd1;
               fast_value = 16'd32768;
            end
            3: begin
               slow_value = 16'd32767;
               fast_value = 16'd1;
            end
            default: begin
               slow_value = 16'($urandom_range(65535));
               fast_value = 16'($urandom_range(65535));
            end
         endcase
         csr_write(REG_SLOW_COEF, slow_value);
         csr_write(REG_FAST_COEF, fast_value);
         case (seg % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 75;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 75;
            end
            default: begin
               sender_idle_pct = 29;
               receiver_stall_pct = 29;
            end
         endcase

         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // Samples: mostly full-range, some near zero, some at the extremes.
            pick = $urandom_range(99);
            if (pick < 10) sample = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            else if (pick < 35) sample = int'($urandom_range(131072)) - 65536;
            else sample = $urandom();
            // Channels: mostly filtered ones, so the stored values build up.
            pick = $urandom_range(99);
            if (pick < 75) channel = 8'($urandom_range(NUM_CHANNELS - 1));
            else if (pick < 85) channel = $urandom_range(1) ? 8'(NUM_CHANNELS) : 8'd255;
            else channel = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 40) mode = MODE_FAST;
            else if (pick < 75) mode = MODE_SLOW;
            else if (pick < 90) mode = MODE_CLEAR;
            else mode = MODE_UNUSED;
            send_sample(sample, channel, mode);
         end
      end

      wait_for_quiet();

      $display("Covered %0d samples (%0d directed) with %0d results compared.",
               accepted_count, directed_count, tracker.compared);
      $display("Coefficient writes: %0d, including 0, 1 and full scale; four idling patterns.",
               settings_written);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("multichannel_ema_lowpass test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", tracker.mismatches,
                  tracker.pending());
         $display("multichannel_ema_lowpass test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/mel_pkg.sv
sv/mel_front.sv
sv/mel_queue.sv
sv/mel_back.sv
sv/multichannel_ema_lowpass.sv
verif/tb_top.sv
